### hdl/bdil_pkg.sv
// Shared constants, codes and types of the 3x3 binary dilation block.
package bdil_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int VALUE_W    = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic             valid;
        logic             pixel;
        logic [COL_W-1:0] addr;
        logic             emit;
        logic             last;
        t_mask            mask;
    } t_issue;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic pixel;
        logic last;
    } t_result;

endpackage

### hdl/binary_dilation_3x3_top.sv
// Top level of the streaming 3x3 binary dilation block.
//
//  channel   direction  handshake              payload
//  request   in         i_valid / o_ready      i_command, i_in_value
//  result    out        o_valid / i_ready      o_out_pixel, o_out_last
//  config    in         i_cfg_wr_en            i_cfg_index, i_cfg_wdata
//
// One request per cycle while o_ready is high; results pass the issue register and the queue.
// Line store reads at issue, writes back in the cycle after; same-column reuse is forwarded.
// The first flush after a one-row frame holds o_ready low for one extra cycle.
// Otherwise o_ready drops only when queued results plus the request in flight reach four.
// Reset clears counters, window and queue; the line store keeps its contents, no clearing pass.
module binary_dilation_3x3_top import bdil_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic signed [VALUE_W-1:0] i_in_value,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_out_pixel,
    output logic                      o_out_last
);

    t_rd_req               rd;
    t_issue                s1;
    logic                  push;
    t_result               result;
    t_result               head;
    logic [FIFO_CNT_W-1:0] fifo_cnt;

    bdil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_in_value (i_in_value),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_fifo_cnt (fifo_cnt),
        .o_rd       (rd),
        .o_s1       (s1)
    );

    bdil_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_s1    (s1),
        .o_push  (push),
        .o_result(result)
    );

    bdil_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (result),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (head),
        .o_count(fifo_cnt)
    );

    assign o_out_pixel = head.pixel;
    assign o_out_last  = head.last;

endmodule

### hdl/bdil_ctrl.sv
// Request decode, frame position counters, configuration and line store read issue.
module bdil_ctrl import bdil_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic signed [VALUE_W-1:0] i_in_value,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [FIFO_CNT_W-1:0]   i_fifo_cnt,
    output t_rd_req                 o_rd,
    output t_issue                  o_s1
);

    logic [WIDTH_W-1:0]  r_w, n_w;
    logic [HEIGHT_W-1:0] r_h, n_h;
    logic [COL_W-1:0]    r_ic, n_ic, r_oc, n_oc;
    logic [ROW_W-1:0]    r_ir, n_ir, r_or, n_or;
    logic                r_done, n_done, r_pad, n_pad;
    t_issue              r_s1, n_s1;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    wm1;
    logic [ROW_W-1:0]    hm1;
    logic                acc, step, pix, is_pixel, primed, pending;
    logic [COL_W-1:0]    base_ic, base_oc;
    logic [ROW_W-1:0]    base_ir, base_or;

    always_comb begin
        if (r_w == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_w > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_w;
        end
        if (r_h == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (r_h > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_h;
        end
    end

    assign wm1     = COL_W'(w_eff - WIDTH_W'(1));
    assign hm1     = ROW_W'(h_eff - HEIGHT_W'(1));
    assign pending = r_done && (r_or < ROW_W'(h_eff));

    assign o_ready = !r_pad &&
        ((FIFO_CNT_W'(i_fifo_cnt) + FIFO_CNT_W'(r_s1.valid)) < FIFO_CNT_W'(FIFO_DEPTH));
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_w      = r_w;
        n_h      = r_h;
        n_ic     = r_ic;
        n_ir     = r_ir;
        n_oc     = r_oc;
        n_or     = r_or;
        n_done   = r_done;
        n_pad    = r_pad;
        n_s1     = '0;
        step     = 1'b0;
        pix      = 1'b0;
        is_pixel = 1'b0;
        base_ic  = r_ic;
        base_ir  = r_ir;
        base_oc  = r_oc;
        base_or  = r_or;

        if (acc && (t_cmd'(i_command) == CMD_PIXEL)) begin
            step     = 1'b1;
            is_pixel = 1'b1;
            pix      = |i_in_value;
            if (r_done) begin
                base_ic = '0;
                base_ir = '0;
                base_oc = '0;
                base_or = '0;
            end
        end else if (acc && (t_cmd'(i_command) == CMD_FLUSH)) begin
            step = pending;
        end else if (r_pad) begin
            step = 1'b1;
        end

        primed = (base_ir >= ROW_W'(2)) || ((base_ir == ROW_W'(1)) && (base_ic != '0));

        if (step) begin
            n_s1.valid      = 1'b1;
            n_s1.pixel      = pix;
            n_s1.addr       = base_ic;
            n_s1.emit       = primed;
            n_s1.last       = (base_or == hm1) && (base_oc == wm1);
            n_s1.mask.top   = (base_or != '0);
            n_s1.mask.bot   = (base_or != hm1);
            n_s1.mask.left  = (base_oc != '0);
            n_s1.mask.right = (base_oc != wm1);

            if (base_ic == wm1) begin
                n_ic = '0;
                n_ir = base_ir + ROW_W'(1);
            end else begin
                n_ic = base_ic + COL_W'(1);
                n_ir = base_ir;
            end

            n_oc = base_oc;
            n_or = base_or;
            if (primed) begin
                if (base_oc == wm1) begin
                    n_oc = '0;
                    n_or = base_or + ROW_W'(1);
                end else begin
                    n_oc = base_oc + COL_W'(1);
                end
            end

            if (is_pixel) begin
                n_done = (base_ir == hm1) && (base_ic == wm1);
                n_pad  = 1'b0;
            end else begin
                n_pad  = !primed;
            end
        end

        if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    n_w = i_cfg_wdata[WIDTH_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    n_h = i_cfg_wdata[HEIGHT_W-1:0];
                end
                default: begin
                    n_w = r_w;
                end
            endcase
            n_ic   = '0;
            n_ir   = '0;
            n_oc   = '0;
            n_or   = '0;
            n_done = 1'b0;
            n_pad  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WIDTH_W'(1024);
            r_h    <= HEIGHT_W'(1024);
            r_ic   <= '0;
            r_ir   <= '0;
            r_oc   <= '0;
            r_or   <= '0;
            r_done <= 1'b0;
            r_pad  <= 1'b0;
            r_s1   <= '0;
        end else begin
            r_w    <= n_w;
            r_h    <= n_h;
            r_ic   <= n_ic;
            r_ir   <= n_ir;
            r_oc   <= n_oc;
            r_or   <= n_or;
            r_done <= n_done;
            r_pad  <= n_pad;
            r_s1   <= n_s1;
        end
    end

    assign o_rd.en   = step;
    assign o_rd.addr = base_ic;
    assign o_s1      = r_s1;

    a_pad_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad |-> r_done)
        else $error("line padding outside a complete frame");

    a_out_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_or <= ROW_W'(h_eff))
        else $error("output row beyond frame height");

endmodule

### hdl/bdil_line.sv
// Two-row line store with read-modify-write, forwarding and the 3x3 window.
module bdil_line import bdil_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_rd_req i_rd,
    input  t_issue  i_s1,
    output logic    o_push,
    output t_result o_result
);

    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rd;
    logic       r_fwd;
    logic [1:0] r_fwd_data;
    logic [2:0] r_left, r_ctr;

    logic [1:0] rd_eff;
    logic [1:0] wr_data;
    logic [2:0] col_new;
    logic       row_t, row_m, row_b, dil;

    assign rd_eff  = r_fwd ? r_fwd_data : r_rd;
    assign wr_data = {rd_eff[0], i_s1.pixel};
    assign col_new = {rd_eff[1], rd_eff[0], i_s1.pixel};

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_mem[i_s1.addr] <= wr_data;
        end
        if (i_rd.en) begin
            r_rd       <= r_mem[i_rd.addr];
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= 1'b0;
            r_left <= '0;
            r_ctr  <= '0;
        end else begin
            if (i_rd.en) begin
                r_fwd <= i_s1.valid && (i_s1.addr == i_rd.addr);
            end
            if (i_s1.valid) begin
                r_left <= r_ctr;
                r_ctr  <= col_new;
            end
        end
    end

    always_comb begin
        row_t = (r_left[2] & i_s1.mask.left) | r_ctr[2] | (col_new[2] & i_s1.mask.right);
        row_m = (r_left[1] & i_s1.mask.left) | r_ctr[1] | (col_new[1] & i_s1.mask.right);
        row_b = (r_left[0] & i_s1.mask.left) | r_ctr[0] | (col_new[0] & i_s1.mask.right);
        dil   = (row_t & i_s1.mask.top) | row_m | (row_b & i_s1.mask.bot);
    end

    assign o_push         = i_s1.valid && i_s1.emit;
    assign o_result.pixel = dil;
    assign o_result.last  = i_s1.last;

endmodule

### hdl/bdil_ofifo.sv
// Four-entry result queue between the window and the output channel.
module bdil_ofifo import bdil_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr, r_rptr;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + FIFO_CNT_W'(1);
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

### verif/tb_binary_dilation_3x3_top.sv
// Self-checking testbench of the streaming 3x3 binary dilation top level.
module tb_binary_dilation_3x3_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdil_pkg::*;

    localparam int unsigned RING_LEN       = 2 * MAX_WIDTH + 3;
    localparam int unsigned SETTLE_CYCLES  = MAX_WIDTH + 16;
    localparam int unsigned HOLD_LEN       = 300;
    localparam int unsigned WATCHDOG_LIMIT = 6 * SETTLE_CYCLES;
    localparam int unsigned RANDOM_ITEMS   = 300;

    class dilation_tracker;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        bit                  ring [RING_LEN];
        int unsigned         pix_count;
        int unsigned         out_count;
        bit                  frame_full;
        t_result             dilated_q [$];
        int unsigned         errors;
        int unsigned         n_pixels;
        int unsigned         n_flushes;
        int unsigned         n_flush_hits;
        int unsigned         n_results;

        function void restart();
            pix_count  = 0;
            out_count  = 0;
            frame_full = 1'b0;
        endfunction

        function void reset();
            width_reg  = WIDTH_W'(1024);
            height_reg = HEIGHT_W'(1024);
            restart();
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h == 0) h = 1;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            return h;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = data[WIDTH_W-1:0];
            end else begin
                height_reg = data[HEIGHT_W-1:0];
            end
            restart();
        endfunction

        function bit window_on(int unsigned q, int unsigned w, int unsigned h);
            int r;
            int c;
            int rr;
            int cc;
            r = int'(q / w);
            c = int'(q % w);
            for (rr = r - 1; rr <= r + 1; rr++) begin
                if (rr < 0 || rr >= int'(h)) continue;
                for (cc = c - 1; cc <= c + 1; cc++) begin
                    if (cc < 0 || cc >= int'(w)) continue;
                    if (ring[(rr * int'(w) + cc) % RING_LEN]) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(t_cmd cmd, logic [VALUE_W-1:0] value);
            int unsigned w;
            int unsigned h;
            int unsigned total;
            int unsigned p;
            int unsigned q;
            t_result     res;
            w = eff_width();
            h = eff_height();
            total = w * h;
            if (cmd == CMD_PIXEL) begin
                n_pixels++;
                if (frame_full) restart();
                p = pix_count;
                ring[p % RING_LEN] = (value != '0);
                pix_count = p + 1;
                if (pix_count >= total) frame_full = 1'b1;
                if (p < w + 1) return;
                q = p - w - 1;
            end else begin
                n_flushes++;
                if (!frame_full || out_count >= total) return;
                q = out_count;
                n_flush_hits++;
            end
            out_count = q + 1;
            res.pixel = window_on(q, w, h);
            res.last  = (q + 1 == total);
            dilated_q.push_back(res);
        endfunction

        function void check_result(logic pixel, logic last);
            t_result want;
            n_results++;
            if (dilated_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: out_pixel %0b out_last %0b",
                         $time, pixel, last);
                return;
            end
            want = dilated_q.pop_front();
            if (pixel !== want.pixel) begin
                errors++;
                $display("%0t: out_pixel mismatch: expected %0b, got %0b",
                         $time, want.pixel, pixel);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: out_last mismatch: expected %0b, got %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_ready;
    logic                      i_command   = CMD_PIXEL;
    logic signed [VALUE_W-1:0] i_in_value  = '0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                      o_valid;
    logic                      i_ready     = 1'b0;
    logic                      o_out_pixel;
    logic                      o_out_last;

    dilation_tracker tracker;
    int unsigned     idle_cycles    = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    bit              hold_toggle    = 1'b0;
    bit              hold_seen      = 1'b0;
    int unsigned     hold_left      = 0;
    int unsigned     n_layouts      = 0;

    binary_dilation_3x3_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_in_value  (i_in_value),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_pixel (o_out_pixel),
        .o_out_last  (o_out_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_seen != hold_toggle) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_valid && o_ready) tracker.note_request(t_cmd'(i_command), i_in_value);
            if (o_valid && i_ready) tracker.check_result(o_out_pixel, o_out_last);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_wr_en) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pixel_value(int unsigned on_pct);
        logic [VALUE_W-1:0] v;
        if ($urandom_range(99) >= on_pct) return '0;
        case ($urandom_range(7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h0000_0001;
            default: v = $urandom;
        endcase
        if (v == '0) v = 32'h0000_0001;
        return v;
    endfunction

    task automatic send_request(t_cmd cmd, logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_in_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.dilated_q.size() != 0);
    endtask

    task automatic hold_receiver();
        hold_toggle <= ~hold_toggle;
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // which: 0 writes both registers, 1 the width only, 2 the height only
    task automatic configure(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                             int unsigned which);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (which != 2) write_reg(REG_IMAGE_WIDTH, wdata);
        if (which != 1) write_reg(REG_IMAGE_HEIGHT, hdata);
        n_layouts++;
    endtask

    task automatic run_frame();
        int unsigned w;
        int unsigned total;
        int unsigned n_pix;
        int unsigned pend;
        int unsigned n_flush;
        int unsigned on_pct;
        int unsigned sel;
        int unsigned k;
        bit          whole;
        bit          pause_mid;
        w = tracker.eff_width();
        total = w * tracker.eff_height();
        case ($urandom_range(5))
            0: on_pct = 0;
            1: on_pct = 4;
            2: on_pct = 15;
            3: on_pct = 35;
            4: on_pct = 70;
            default: on_pct = 100;
        endcase
        whole = (total <= 160) && (total == 1 || $urandom_range(99) < 85);
        if (whole) begin
            n_pix = total;
        end else begin
            n_pix = $urandom_range(1, (total - 1 < 60) ? total - 1 : 60);
        end
        pause_mid = ($urandom_range(99) < 8);
        if ($urandom_range(99) < 6) hold_receiver();
        for (k = 0; k < n_pix; k++) begin
            if ($urandom_range(99) < 4) send_request(CMD_FLUSH, $urandom);
            if (pause_mid && k == n_pix / 2) drain_results();
            send_request(CMD_PIXEL, pixel_value(on_pct));
        end
        pend = (total <= w + 1) ? total : w + 1;
        if (whole) begin
            sel = $urandom_range(99);
            if (sel < 75) n_flush = pend;
            else if (sel < 88) n_flush = pend + $urandom_range(1, 3);
            else n_flush = $urandom_range(0, pend - 1);
        end else begin
            n_flush = $urandom_range(0, 2);
        end
        repeat (n_flush) send_request(CMD_FLUSH, $urandom);
    endtask

    initial begin : stimulus
        logic [VALUE_W-1:0]    grid3 [9];
        logic [CFG_DATA_W-1:0] wdata;
        int unsigned           wv;
        int unsigned           hv;
        int unsigned           sel;
        int unsigned           base;
        int unsigned           phase;
        int unsigned           k;

        tracker = new();
        tracker.reset();
        grid3 = '{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero-sized registers act as a 1x1 frame
        configure('0, '0, 0);
        send_request(CMD_PIXEL, 32'h8000_0000);
        send_request(CMD_FLUSH, '0);
        send_request(CMD_FLUSH, 32'hFFFF_FFFF);

        configure(13'd3, 13'd3, 0);
        for (k = 0; k < 9; k++) send_request(CMD_PIXEL, grid3[k]);
        repeat (4) send_request(CMD_FLUSH, 32'h5555_5555);

        // flush mid-frame, then a register write drops the partial frame
        configure(13'd2, 13'd3, 0);
        send_request(CMD_PIXEL, 32'h0000_0001);
        send_request(CMD_FLUSH, 32'hAAAA_AAAA);

        // a new frame drops the outputs still waiting for a flush
        configure(13'd2, 13'd1, 0);
        send_request(CMD_PIXEL, 32'h0000_0001);
        send_request(CMD_PIXEL, '0);
        send_request(CMD_FLUSH, '0);
        send_request(CMD_PIXEL, '0);
        send_request(CMD_PIXEL, '0);
        send_request(CMD_FLUSH, '0);
        send_request(CMD_FLUSH, '0);

        // widest row, with the output side held off once results start
        set_idling(35, 35);
        configure(13'h1FFF, 13'h1FFF, 0);
        for (k = 0; k < MAX_WIDTH + 1; k++) send_request(CMD_PIXEL, pixel_value(3));
        hold_receiver();
        for (k = 0; k < 40; k++) send_request(CMD_PIXEL, pixel_value(3));
        drain_results();
        configure(13'd1024, 13'd4096, 0);
        for (k = 0; k < 30; k++) send_request(CMD_PIXEL, pixel_value(50));

        base = tracker.n_pixels + tracker.n_flushes;
        phase = 0;
        while (tracker.n_pixels + tracker.n_flushes < base + RANDOM_ITEMS) begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(52, 0);
                2: set_idling(0, 52);
                default: set_idling(35, 35);
            endcase
            sel = $urandom_range(99);
            if (sel < 55) begin
                wv = $urandom_range(1, 6);
                hv = $urandom_range(1, 6);
            end else if (sel < 70) begin
                wv = $urandom_range(0, 2);
                hv = $urandom_range(0, 9);
            end else if (sel < 90) begin
                wv = $urandom_range(7, 40);
                hv = $urandom_range(0, 4);
            end else begin
                case ($urandom_range(4))
                    0: wv = 0;
                    1: wv = 1;
                    2: wv = 1023;
                    3: wv = 1024;
                    default: wv = 2047;
                endcase
                case ($urandom_range(3))
                    0: hv = 0;
                    1: hv = 1;
                    2: hv = 4096;
                    default: hv = 8191;
                endcase
            end
            wdata = CFG_DATA_W'(wv);
            if ($urandom_range(3) == 0) begin
                wdata[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W-WIDTH_W)'($urandom_range(3));
            end
            sel = $urandom_range(9);
            configure(wdata, CFG_DATA_W'(hv), (sel < 2) ? sel + 1 : 0);
            repeat ($urandom_range(1, 4)) run_frame();
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d pixel and %0d flush requests (%0d emitting), %0d layouts,",
                 tracker.n_pixels, tracker.n_flushes, tracker.n_flush_hits, n_layouts);
        $display("clipped edges, saturated sizes, dropped outputs and stalls; %0d results",
                 tracker.n_results);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
